// ===== hw/rtl/cnv_pkg.sv =====
// shared types, constants and helpers for the 3x3 convolution layer
package cnv_pkg;

    localparam int MAX_SIDE         = 32;
    localparam int MAX_IN_CHANNELS  = 16;
    localparam int MAX_OUT_CHANNELS = 16;
    localparam int KERNEL_SIDE      = 3;
    localparam int KERNEL_TAPS      = KERNEL_SIDE * KERNEL_SIDE;
    localparam int KERNEL_HALF      = KERNEL_SIDE / 2;

    localparam int FEAT_DEPTH   = 16384;
    localparam int WEIGHT_DEPTH = 2304;
    localparam int BIAS_DEPTH   = 16;
    localparam int FEAT_AW      = 14;
    localparam int WEIGHT_AW    = 12;
    localparam int BIAS_AW      = 4;
    localparam int KCNT_W       = 2;
    localparam int ACC_W        = 40;

    localparam logic [14:0] SAT_MAX = 15'h7FFF;

    // configuration register indexes
    localparam logic [1:0] REG_MAP_SIDE     = 2'd0;
    localparam logic [1:0] REG_IN_CHANNELS  = 2'd1;
    localparam logic [1:0] REG_OUT_CHANNELS = 2'd2;

    typedef enum logic [1:0] {
        MODE_LOAD_FEAT   = 2'd0,
        MODE_LOAD_WEIGHT = 2'd1,
        MODE_LOAD_BIAS   = 2'd2,
        MODE_COMPUTE     = 2'd3
    } cnv_mode_t;

    typedef struct packed {
        cnv_mode_t          mode;
        logic [13:0]        address;
        logic signed [15:0] value;
        logic [3:0]         out_channel;
        logic [4:0]         row;
        logic [4:0]         col;
    } cnv_in_t;

    typedef struct packed {
        logic [14:0] conv_value;
        logic [3:0]  res_channel;
        logic [4:0]  res_row;
        logic [4:0]  res_col;
    } cnv_out_t;

    // saturate a raw register into 1..hi
    function automatic logic [5:0] clamp_reg(input logic [5:0] v, input logic [5:0] hi);
        logic [5:0] r;
        begin
            if (v == 6'd0)
                r = 6'd1;
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/conv3x3_bias_relu_layer.sv =====
// convolution layer top level: stores, tap sequencer and shared multiply-accumulate
//
//  channel  signals                                    direction  handshake
//  command  start, busy, cmd                           in         start & !busy
//  result   done, result                               out        done strobe, one cycle
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  in         valid & ready
//
// loads and requests outside the map leave busy low and can follow back to back
// a compute word holds busy through these steps:
// setup, one tap a cycle on the one multiplier, a drain until the product pipe empties, finish
// taps outside the map are skipped but still take their turn in the loop; done follows busy
// reset clears control state only; store contents are undefined until written
// the receiver cannot stall: the result is valid with done and holds until the next finish
module conv3x3_bias_relu_layer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cnv_pkg::cnv_in_t cmd,
    output logic             done,
    output cnv_pkg::cnv_out_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [5:0]       cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_MAC    = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0] map_side_reg;
    logic [4:0] in_ch_reg;
    logic [4:0] out_ch_reg;

    logic [5:0] side_eff;
    logic [4:0] cin_eff;
    logic [4:0] cout_eff;

    logic signed [15:0] feat_mem [cnv_pkg::FEAT_DEPTH];
    logic signed [15:0] wt_mem   [cnv_pkg::WEIGHT_DEPTH];
    logic signed [15:0] bias_reg [cnv_pkg::BIAS_DEPTH];
    logic signed [15:0] feat_q_reg;
    logic signed [15:0] wt_q_reg;

    logic [3:0] och_reg;
    logic [4:0] row_reg;
    logic [4:0] col_reg;

    logic [3:0]                      c_reg, c_next;
    logic [cnv_pkg::KCNT_W-1:0]      i_reg, i_next;
    logic [cnv_pkg::KCNT_W-1:0]      j_reg, j_next;
    logic [cnv_pkg::FEAT_AW-1:0]     ss_reg;
    logic [cnv_pkg::FEAT_AW-1:0]     rowm1_reg;
    logic [cnv_pkg::FEAT_AW-1:0]     chan_base_reg, chan_base_next;
    logic [cnv_pkg::FEAT_AW-1:0]     row_off_reg, row_off_next;
    logic [cnv_pkg::WEIGHT_AW-1:0]   w_addr_reg, w_addr_next;

    logic                     rd_vld_reg;
    logic                     prod_vld_reg;
    logic signed [31:0]       prod_reg;
    logic [cnv_pkg::ACC_W-1:0] acc_reg, acc_next;

    logic                     done_reg;
    cnv_pkg::cnv_out_t        result_reg;

    logic                        accept;
    logic                        req_ok;
    logic [5:0]                  ys;
    logic [5:0]                  xs;
    logic                        tap_in;
    logic                        tap_last;
    logic [cnv_pkg::FEAT_AW-1:0] feat_raddr;
    logic [cnv_pkg::FEAT_AW-1:0] rowm1_calc;
    logic [cnv_pkg::ACC_W-1:0]   sum;
    logic [14:0]                 relu_val;

    assign side_eff = cnv_pkg::clamp_reg(map_side_reg, 6'(cnv_pkg::MAX_SIDE));
    assign cin_eff  = 5'(cnv_pkg::clamp_reg({1'b0, in_ch_reg}, 6'(cnv_pkg::MAX_IN_CHANNELS)));
    assign cout_eff = 5'(cnv_pkg::clamp_reg({1'b0, out_ch_reg}, 6'(cnv_pkg::MAX_OUT_CHANNELS)));

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign req_ok = ({1'b0, cmd.row} < side_eff) && ({1'b0, cmd.col} < side_eff)
                    && ({1'b0, cmd.out_channel} < cout_eff);

    // tap position and bounds
    assign ys = 6'(row_reg) + 6'(i_reg);
    assign xs = 6'(col_reg) + 6'(j_reg);
    assign tap_in = (ys >= 6'(cnv_pkg::KERNEL_HALF))
                    && ({1'b0, ys} < 7'(side_eff) + 7'(cnv_pkg::KERNEL_HALF))
                    && (xs >= 6'(cnv_pkg::KERNEL_HALF))
                    && ({1'b0, xs} < 7'(side_eff) + 7'(cnv_pkg::KERNEL_HALF));
    assign tap_last = (c_reg == 4'(cin_eff - 5'd1))
                      && (i_reg == cnv_pkg::KCNT_W'(cnv_pkg::KERNEL_SIDE - 1))
                      && (j_reg == cnv_pkg::KCNT_W'(cnv_pkg::KERNEL_SIDE - 1));
    assign feat_raddr = row_off_reg + 14'(col_reg) + 14'(j_reg)
                        - 14'(cnv_pkg::KERNEL_HALF);

    assign rowm1_calc = 14'(row_reg) * 14'(side_eff)
                        - 14'(cnv_pkg::KERNEL_HALF) * 14'(side_eff);

    // bias alignment, relu and saturation
    assign sum = acc_reg + {{(cnv_pkg::ACC_W - 24){bias_reg[och_reg][15]}},
                            bias_reg[och_reg], 8'd0};
    always_comb
    begin
        if (sum[cnv_pkg::ACC_W-1])
            relu_val = 15'd0;
        else if (sum[cnv_pkg::ACC_W-2:8] > 31'(cnv_pkg::SAT_MAX))
            relu_val = cnv_pkg::SAT_MAX;
        else
            relu_val = sum[22:8];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        c_next         = c_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        chan_base_next = chan_base_reg;
        row_off_next   = row_off_reg;
        w_addr_next    = w_addr_reg;
        acc_next       = acc_reg;
        if (prod_vld_reg)
            acc_next = acc_reg + {{(cnv_pkg::ACC_W - 32){prod_reg[31]}}, prod_reg};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.mode == cnv_pkg::MODE_COMPUTE && req_ok)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                c_next         = '0;
                i_next         = '0;
                j_next         = '0;
                chan_base_next = '0;
                row_off_next   = rowm1_calc;
                w_addr_next    = 12'(och_reg) * 12'(cin_eff) * 12'(cnv_pkg::KERNEL_TAPS);
                acc_next       = '0;
                state_next     = ST_MAC;
            end
            ST_MAC:
            begin
                w_addr_next = w_addr_reg + 12'd1;
                if (tap_last)
                    state_next = ST_DRAIN;
                if (j_reg == cnv_pkg::KCNT_W'(cnv_pkg::KERNEL_SIDE - 1))
                begin
                    j_next = '0;
                    if (i_reg == cnv_pkg::KCNT_W'(cnv_pkg::KERNEL_SIDE - 1))
                    begin
                        i_next         = '0;
                        c_next         = c_reg + 4'd1;
                        chan_base_next = chan_base_reg + ss_reg;
                        row_off_next   = chan_base_reg + ss_reg + rowm1_reg;
                    end
                    else
                    begin
                        i_next       = i_reg + 2'd1;
                        row_off_next = row_off_reg + 14'(side_eff);
                    end
                end
                else
                begin
                    j_next = j_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            map_side_reg  <= 6'd32;
            in_ch_reg     <= 5'd3;
            out_ch_reg    <= 5'd16;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= (state_reg == ST_MAC) && tap_in;
            prod_vld_reg <= rd_vld_reg;
            done_reg     <= (state_reg == ST_FINISH);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cnv_pkg::REG_MAP_SIDE:     map_side_reg <= cfg_data;
                    cnv_pkg::REG_IN_CHANNELS:  in_ch_reg    <= cfg_data[4:0];
                    cnv_pkg::REG_OUT_CHANNELS: out_ch_reg   <= cfg_data[4:0];
                    default:                   ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        c_reg         <= c_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        chan_base_reg <= chan_base_next;
        row_off_reg   <= row_off_next;
        w_addr_reg    <= w_addr_next;
        acc_reg       <= acc_next;
        prod_reg      <= feat_q_reg * wt_q_reg;
        if (state_reg == ST_SETUP)
        begin
            ss_reg    <= 14'(side_eff) * 14'(side_eff);
            rowm1_reg <= rowm1_calc;
        end
        if (accept)
        begin
            och_reg <= cmd.out_channel;
            row_reg <= cmd.row;
            col_reg <= cmd.col;
        end
        if (state_reg == ST_FINISH)
        begin
            result_reg.conv_value  <= relu_val;
            result_reg.res_channel <= och_reg;
            result_reg.res_row     <= row_reg;
            result_reg.res_col     <= col_reg;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (accept && cmd.mode == cnv_pkg::MODE_LOAD_FEAT)
            feat_mem[cmd.address] <= cmd.value;
        feat_q_reg <= feat_mem[feat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.mode == cnv_pkg::MODE_LOAD_WEIGHT
            && cmd.address < 14'(cnv_pkg::WEIGHT_DEPTH))
            wt_mem[cmd.address[cnv_pkg::WEIGHT_AW-1:0]] <= cmd.value;
        wt_q_reg <= wt_mem[w_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.mode == cnv_pkg::MODE_LOAD_BIAS
            && cmd.address < 14'(cnv_pkg::BIAS_DEPTH))
            bias_reg[cmd.address[cnv_pkg::BIAS_AW-1:0]] <= cmd.value;
    end

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result strobe without finish step");

    a_read_only_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_MAC))
        else $error("tap read outside the accumulate loop");

    a_pipe_empty_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("products still in flight at finish");

    a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> ({1'b0, c_reg} < cin_eff))
        else $error("channel counter past in_channels");

endmodule

// ===== tb/tb_top.sv =====
// testbench for the 3x3 convolution layer: directed and random loads and pixel requests against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cnv_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int SETTLE_CYCLES  = 1 + KERNEL_TAPS * MAX_IN_CHANNELS + 3 + 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] REG_NONE = 2'd3;

    class conv_pixel_check;
        logic [15:0] feat_mem [FEAT_DEPTH];
        logic [15:0] wgt_mem [WEIGHT_DEPTH];
        logic [15:0] bias_mem [BIAS_DEPTH];
        logic [5:0]  side_raw;
        logic [4:0]  cin_raw;
        logic [4:0]  cout_raw;
        cnv_out_t    pending_pixels [$];
        int          mismatches;

        function new();
            side_raw   = 6'd32;
            cin_raw    = 5'd3;
            cout_raw   = 5'd16;
            mismatches = 0;
        endfunction

        function int limit_to(int v, int hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int eff_side();
            return limit_to(side_raw, MAX_SIDE);
        endfunction

        function int eff_cin();
            return limit_to(cin_raw, MAX_IN_CHANNELS);
        endfunction

        function int eff_cout();
            return limit_to(cout_raw, MAX_OUT_CHANNELS);
        endfunction

        function void write_reg(logic [1:0] idx, logic [5:0] data);
            case (idx)
                REG_MAP_SIDE:     side_raw = data;
                REG_IN_CHANNELS:  cin_raw  = data[4:0];
                REG_OUT_CHANNELS: cout_raw = data[4:0];
                default: ;
            endcase
        endfunction

        function void predict_pixel(cnv_in_t w);
            int s, ci, och, y, x;
            logic signed [15:0] f, k;
            logic signed [31:0] prod;
            logic signed [39:0] acc, bias_q;
            logic [39:0] scaled;
            cnv_out_t r;
            s   = eff_side();
            ci  = eff_cin();
            och = w.out_channel;
            if (w.row >= s || w.col >= s || och >= eff_cout())
                return;
            acc = '0;
            for (int c = 0; c < ci; c++)
            begin
                for (int i = 0; i < KERNEL_SIDE; i++)
                begin
                    for (int j = 0; j < KERNEL_SIDE; j++)
                    begin
                        y = w.row;
                        y = y + i - KERNEL_HALF;
                        x = w.col;
                        x = x + j - KERNEL_HALF;
                        if (y < 0 || y >= s || x < 0 || x >= s)
                            continue;
                        f = feat_mem[c * s * s + y * s + x];
                        k = wgt_mem[och * ci * KERNEL_TAPS + c * KERNEL_TAPS
                                    + i * KERNEL_SIDE + j];
                        prod = f * k;
                        acc  = acc + prod;
                    end
                end
            end
            f      = bias_mem[och];
            bias_q = f;
            acc    = acc + (bias_q <<< 8);
            if (acc < 0)
                r.conv_value = '0;
            else
            begin
                scaled       = acc >>> 8;
                r.conv_value = (scaled > 40'd32767) ? SAT_MAX : scaled[14:0];
            end
            r.res_channel = w.out_channel;
            r.res_row     = w.row;
            r.res_col     = w.col;
            pending_pixels.push_back(r);
        endfunction

        function void note_word(cnv_in_t w);
            case (w.mode)
                MODE_LOAD_FEAT:
                    if (w.address < FEAT_DEPTH)
                        feat_mem[w.address] = w.value;
                MODE_LOAD_WEIGHT:
                    if (w.address < WEIGHT_DEPTH)
                        wgt_mem[w.address] = w.value;
                MODE_LOAD_BIAS:
                    if (w.address < BIAS_DEPTH)
                        bias_mem[w.address] = w.value;
                default:
                    predict_pixel(w);
            endcase
        endfunction

        function void check_pixel(cnv_out_t got);
            cnv_out_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("result with none pending: channel %0d row %0d col %0d",
                       got.res_channel, got.res_row, got.res_col);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.conv_value !== want.conv_value)
            begin
                $error("conv_value: expected %0d, got %0d", want.conv_value, got.conv_value);
                mismatches++;
            end
            if (got.res_channel !== want.res_channel)
            begin
                $error("res_channel: expected %0d, got %0d", want.res_channel, got.res_channel);
                mismatches++;
            end
            if (got.res_row !== want.res_row)
            begin
                $error("res_row: expected %0d, got %0d", want.res_row, got.res_row);
                mismatches++;
            end
            if (got.res_col !== want.res_col)
            begin
                $error("res_col: expected %0d, got %0d", want.res_col, got.res_col);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    cnv_in_t    cmd;
    logic       done;
    cnv_out_t   result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [5:0] cfg_data;

    conv_pixel_check sb;
    bit feat_done [FEAT_DEPTH];
    bit wgt_done [WEIGHT_DEPTH];
    bit bias_done [BIAS_DEPTH];
    bit steady;
    int idle_cycles;
    int items_sent;

    conv3x3_bias_relu_layer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_pixel(result);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] rand_value();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(1023)) - 16'd512;
    endfunction

    task automatic issue_word(input cnv_in_t w);
        while (!steady && $urandom_range(99) < 17)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        sb.note_word(w);
    endtask

    task automatic load_entry(input cnv_mode_t m, input logic [13:0] a, input logic [15:0] v);
        cnv_in_t w;
        w.mode        = m;
        w.address     = a;
        w.value       = v;
        w.out_channel = 4'($urandom);
        w.row         = 5'($urandom);
        w.col         = 5'($urandom);
        issue_word(w);
        case (m)
            MODE_LOAD_FEAT:   feat_done[a] = 1'b1;
            MODE_LOAD_WEIGHT: if (a < WEIGHT_DEPTH) wgt_done[a] = 1'b1;
            default:          if (a < BIAS_DEPTH) bias_done[a] = 1'b1;
        endcase
    endtask

    // make sure every entry the window reads has been written
    task automatic fill_window(input int och, input int row, input int col);
        int s, ci, y, x, fa, wa;
        s  = sb.eff_side();
        ci = sb.eff_cin();
        for (int c = 0; c < ci; c++)
        begin
            for (int i = 0; i < KERNEL_SIDE; i++)
            begin
                for (int j = 0; j < KERNEL_SIDE; j++)
                begin
                    y = row + i - KERNEL_HALF;
                    x = col + j - KERNEL_HALF;
                    if (y < 0 || y >= s || x < 0 || x >= s)
                        continue;
                    fa = c * s * s + y * s + x;
                    wa = och * ci * KERNEL_TAPS + c * KERNEL_TAPS + i * KERNEL_SIDE + j;
                    if (!feat_done[fa])
                        load_entry(MODE_LOAD_FEAT, 14'(fa), rand_value());
                    if (!wgt_done[wa])
                        load_entry(MODE_LOAD_WEIGHT, 14'(wa), rand_value());
                end
            end
        end
        if (!bias_done[och])
            load_entry(MODE_LOAD_BIAS, 14'(och), rand_value());
    endtask

    task automatic request_pixel(input int och, input int row, input int col);
        cnv_in_t w;
        if (row < sb.eff_side() && col < sb.eff_side() && och < sb.eff_cout())
            fill_window(och, row, col);
        w.mode        = MODE_COMPUTE;
        w.address     = 14'($urandom);
        w.value       = 16'($urandom);
        w.out_channel = 4'(och);
        w.row         = 5'(row);
        w.col         = 5'(col);
        issue_word(w);
    endtask

    task automatic drain_pixels();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [5:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_layer(input logic [5:0] side, input logic [5:0] cin,
                             input logic [5:0] cout);
        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(REG_MAP_SIDE, side);
        cfg_write(REG_IN_CHANNELS, cin);
        cfg_write(REG_OUT_CHANNELS, cout);
    endtask

    task automatic random_word();
        int s, ci, co, pick;
        logic [13:0] a;
        s    = sb.eff_side();
        ci   = sb.eff_cin();
        co   = sb.eff_cout();
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            if ($urandom_range(9) != 0)
                request_pixel($urandom_range(co - 1), $urandom_range(s - 1),
                              $urandom_range(s - 1));
            else
                request_pixel($urandom_range(15), $urandom_range(31), $urandom_range(31));
        end
        else if (pick < 70)
        begin
            a = ($urandom_range(9) < 7) ? 14'($urandom_range(ci * s * s - 1)) : 14'($urandom);
            load_entry(MODE_LOAD_FEAT, a, rand_value());
        end
        else if (pick < 88)
        begin
            a = ($urandom_range(9) != 0) ? 14'($urandom_range(co * ci * KERNEL_TAPS - 1))
                                         : 14'($urandom);
            load_entry(MODE_LOAD_WEIGHT, a, rand_value());
        end
        else
        begin
            a = ($urandom_range(4) != 0) ? 14'($urandom_range(co - 1)) : 14'($urandom);
            load_entry(MODE_LOAD_BIAS, a, rand_value());
        end
        if ($urandom_range(99) < 2)
            drain_pixels();
    endtask

    // n is the least number of words accepted in this setting, fill loads included
    task automatic run_setting(input logic [5:0] side, input logic [5:0] cin,
                               input logic [5:0] cout, input int n, input bit quiet);
        int stop;
        set_layer(side, cin, cout);
        stop   = items_sent + n;
        steady = quiet;
        while (items_sent < stop)
            random_word();
        steady = 1'b0;
    endtask

    initial
    begin
        sb          = new();
        steady      = 1'b0;
        idle_cycles = 0;
        items_sent  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_MAP_SIDE;
        cfg_data    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pixel map, one input channel, two filters
        set_layer(6'd1, 6'd1, 6'd2);
        cfg_write(REG_NONE, 6'h3F);
        load_entry(MODE_LOAD_FEAT, 14'd0, 16'h7FFF);
        load_entry(MODE_LOAD_WEIGHT, 14'd4, 16'h7FFF);
        load_entry(MODE_LOAD_BIAS, 14'd0, 16'h7FFF);
        request_pixel(0, 0, 0);
        load_entry(MODE_LOAD_WEIGHT, 14'd13, 16'h8000);
        load_entry(MODE_LOAD_BIAS, 14'd1, 16'h8000);
        request_pixel(1, 0, 0);
        load_entry(MODE_LOAD_FEAT, 14'd0, 16'h8000);
        request_pixel(1, 0, 0);
        request_pixel(0, 0, 0);
        load_entry(MODE_LOAD_FEAT, 14'd0, 16'h0180);
        load_entry(MODE_LOAD_WEIGHT, 14'd4, 16'h0200);
        load_entry(MODE_LOAD_BIAS, 14'd0, 16'hFF00);
        request_pixel(0, 0, 0);
        // writes past the end of the weight and bias stores are dropped
        load_entry(MODE_LOAD_BIAS, 14'd16, 16'h1234);
        load_entry(MODE_LOAD_BIAS, 14'h3FFF, 16'h4321);
        load_entry(MODE_LOAD_WEIGHT, 14'h3FFF, 16'h7FFF);
        load_entry(MODE_LOAD_FEAT, 14'h3FFF, 16'h0001);
        request_pixel(0, 0, 0);
        // requests outside the map or filter range
        request_pixel(0, 1, 0);
        request_pixel(0, 0, 31);
        request_pixel(2, 0, 0);
        request_pixel(15, 31, 31);

        run_setting(6'd32, 6'd3, 6'd16, 80, 1'b0);
        run_setting(6'd0, 6'd0, 6'd0, 30, 1'b0);
        run_setting(6'd63, 6'd2, 6'd31, 50, 1'b0);
        run_setting(6'd4, 6'd2, 6'd3, 100, 1'b1);
        run_setting(6'd8, 6'd5, 6'd4, 70, 1'b0);
        run_setting(6'd1, 6'd16, 6'd16, 50, 1'b0);
        run_setting(6'd1, 6'd33, 6'd48, 40, 1'b0);
        repeat (2)
            run_setting(6'($urandom_range(12, 1)), 6'($urandom_range(6, 1)),
                        6'($urandom_range(16, 1)), 40, 1'b0);

        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cnv_pkg.sv
hw/rtl/conv3x3_bias_relu_layer.sv
tb/tb_top.sv
